// ----- rtl/mfat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_pkg: shared definitions for the motor feedback angle tracker
// Encoder geometry, register indexes, multiplier operand codes and the
// control bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package mfat_pkg;

  // The output field widths are fixed at a 13-bit encoder, so the span is a
  // power of two and every wrap is a mask.
  localparam int SPAN_BITS    = 13;
  localparam int ENCODER_SPAN = 1 << SPAN_BITS;
  localparam int HALF_SPAN    = ENCODER_SPAN / 2;

  // Configuration register indexes
  localparam logic [1:0] REG_ZERO_OFFSET  = 2'd0;
  localparam logic [1:0] REG_INV_RATIO    = 2'd1;
  localparam logic [1:0] REG_TORQUE_GAIN  = 2'd2;
  localparam logic [1:0] REG_CURRENT_GAIN = 2'd3;

  // Operand selection for the shared multiplier
  localparam logic [1:0] OP_INC = 2'd0;
  localparam logic [1:0] OP_TRQ = 2'd1;
  localparam logic [1:0] OP_SPD = 2'd2;
  localparam logic [1:0] OP_CUR = 2'd3;

  // Shared multiplier widths
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic       accept;
    logic       mul_en;
    logic [1:0] op_sel;
    logic       use_inc;
    logic       use_trq;
    logic       use_spd;
    logic       finish;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/mfat_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_mul: shared signed multiplier
// One signed multiply per enabled cycle, with the product registered.
// ----------------------------------------------------------------------------
module mfat_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [mfat_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [mfat_pkg::MUL_B_W-1:0] b,
  output logic signed [mfat_pkg::PROD_W-1:0]       prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mfat_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_ctrl: step sequencer
// Walks one frame through the four multiplies and hands the result to the
// output register once it is free.
// ----------------------------------------------------------------------------
module mfat_ctrl (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     out_free,
  output logic          in_ready,
  output mfat_pkg::ctrl_t ctrl
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INC  = 3'd1;
  localparam logic [2:0] ST_TRQ  = 3'd2;
  localparam logic [2:0] ST_SPD  = 3'd3;
  localparam logic [2:0] ST_CUR  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next   = state;
    ctrl         = '0;
    ctrl.op_sel  = mfat_pkg::OP_INC;
    unique case (state)
      ST_IDLE: begin
        ctrl.accept = in_valid;
        if (in_valid) state_next = ST_INC;
      end
      ST_INC: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = mfat_pkg::OP_INC;
        state_next  = ST_TRQ;
      end
      ST_TRQ: begin
        ctrl.mul_en  = 1'b1;
        ctrl.op_sel  = mfat_pkg::OP_TRQ;
        ctrl.use_inc = 1'b1;
        state_next   = ST_SPD;
      end
      ST_SPD: begin
        ctrl.mul_en  = 1'b1;
        ctrl.op_sel  = mfat_pkg::OP_SPD;
        ctrl.use_trq = 1'b1;
        state_next   = ST_CUR;
      end
      ST_CUR: begin
        ctrl.mul_en  = 1'b1;
        ctrl.op_sel  = mfat_pkg::OP_CUR;
        ctrl.use_spd = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        // The current product is held in the multiplier until the output
        // register can take the result.
        ctrl.finish = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/motor_feedback_angle_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The sequencer takes a frame in IDLE and runs its four products through one
// shared multiplier, one per cycle, in INC, TRQ, SPD and CUR; no new frame
// is taken until DONE has handed the result to the output register.
// A finished result waits in the output register, so the next frame may enter.
// Synchronous reset: registers at their defaults, block offline, accumulator
// and speed at zero, no result pending.
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker: encoder multi-turn unwrap
// Unwraps the single-turn encoder angle into a saturating Q16 multi-turn
// position through the gear ratio, and derives speed, torque and current.
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [12:0]        raw_angle,
  input  wire logic signed [15:0] raw_torque,
  input  wire logic [15:0]        frame_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [12:0]             angle_from_zero,
  output logic signed [47:0]      multi_turn_angle,
  output logic [28:0]             single_turn_angle,
  output logic signed [28:0]      speed,
  output logic signed [15:0]      torque,
  output logic signed [15:0]      current,
  output logic                    online
);

  localparam int SB = mfat_pkg::SPAN_BITS;
  localparam logic signed [SB+1:0] HALF_W = (SB+2)'(mfat_pkg::HALF_SPAN);
  localparam logic signed [SB+1:0] SPAN_W = (SB+2)'(mfat_pkg::ENCODER_SPAN);

  // Configuration
  logic [12:0] zero_offset;
  logic [16:0] inv_ratio_q16;
  logic [23:0] torque_gain_q16;
  logic [23:0] current_gain_q16;

  // Tracker state
  logic [12:0]        last_raw_angle;
  logic               online_flag;
  logic signed [47:0] turn_accumulator;
  logic signed [28:0] last_speed;

  // Per-frame working registers
  logic [12:0]        raw_q;
  logic signed [15:0] tcode_q;
  logic [15:0]        rate_q;
  logic signed [13:0] diff_q;
  logic               sync_q;
  logic [12:0]        rel_q;
  logic signed [30:0] inc_q;
  logic signed [24:0] torq_q;

  mfat_pkg::ctrl_t ctrl;
  logic            out_free;

  logic signed [mfat_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mfat_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mfat_pkg::PROD_W-1:0]  prod;

  logic signed [SB+1:0] diff_raw;
  logic signed [SB+1:0] diff_wrap;
  logic signed [48:0]   acc_sum;
  logic signed [30:0]   spd_full;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [15:0] r;
    if ((v[32:15] == '0) || (v[32:15] == '1)) r = v[15:0];
    else r = {v[32], {15{~v[32]}}};
    return r;
  endfunction

  assign out_free = !out_valid || out_ready;

  mfat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  mfat_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Shortest-arc step: a difference of exactly half a turn is kept.
  always_comb begin
    diff_raw = $signed({2'b00, raw_angle}) - $signed({2'b00, last_raw_angle});
    if (diff_raw > HALF_W) diff_wrap = diff_raw - SPAN_W;
    else if (diff_raw < -HALF_W) diff_wrap = diff_raw + SPAN_W;
    else diff_wrap = diff_raw;
  end

  always_comb begin
    unique case (ctrl.op_sel)
      mfat_pkg::OP_INC: begin
        mul_a = sync_q ? $signed({18'd0, raw_q}) : $signed({{17{diff_q[13]}}, diff_q});
        mul_b = $signed({8'd0, inv_ratio_q16});
      end
      mfat_pkg::OP_TRQ: begin
        mul_a = $signed({{15{tcode_q[15]}}, tcode_q});
        mul_b = $signed({1'b0, torque_gain_q16});
      end
      mfat_pkg::OP_SPD: begin
        mul_a = inc_q;
        mul_b = $signed({9'd0, rate_q});
      end
      mfat_pkg::OP_CUR: begin
        mul_a = $signed({{6{torq_q[24]}}, torq_q});
        mul_b = $signed({1'b0, current_gain_q16});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_sum  = $signed({turn_accumulator[47], turn_accumulator})
                  + $signed({{18{prod[30]}}, prod[30:0]});
  assign spd_full = prod[46:16];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset      <= '0;
      inv_ratio_q16    <= 17'h10000;
      torque_gain_q16  <= 24'h010000;
      current_gain_q16 <= 24'h010000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfat_pkg::REG_ZERO_OFFSET:  zero_offset      <= cfg_data[12:0];
        mfat_pkg::REG_INV_RATIO:    inv_ratio_q16    <= cfg_data[16:0];
        mfat_pkg::REG_TORQUE_GAIN:  torque_gain_q16  <= cfg_data;
        mfat_pkg::REG_CURRENT_GAIN: current_gain_q16 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_angle   <= '0;
      online_flag      <= 1'b0;
      turn_accumulator <= '0;
      last_speed       <= '0;
    end else begin
      if (ctrl.accept) begin
        last_raw_angle <= raw_angle;
        if (raw_angle != last_raw_angle) online_flag <= 1'b1;
      end
      if (ctrl.use_inc) begin
        if (sync_q) begin
          turn_accumulator <= $signed({18'd0, prod[29:0]});
        end else if (acc_sum[48] != acc_sum[47]) begin
          turn_accumulator <= {acc_sum[48], {47{~acc_sum[48]}}};
        end else begin
          turn_accumulator <= acc_sum[47:0];
        end
      end
      if (ctrl.use_spd && (rate_q > 16'd1)) begin
        if ((spd_full[30:28] == 3'b000) || (spd_full[30:28] == 3'b111)) begin
          last_speed <= spd_full[28:0];
        end else begin
          last_speed <= {spd_full[30], {28{~spd_full[30]}}};
        end
      end
    end
  end

  // Per-frame working registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      raw_q   <= raw_angle;
      tcode_q <= raw_torque;
      rate_q  <= frame_rate;
      diff_q  <= diff_wrap[SB:0];
      sync_q  <= !online_flag && (raw_angle != last_raw_angle);
      rel_q   <= raw_angle - zero_offset;
    end
    if (ctrl.use_inc) begin
      inc_q <= sync_q ? '0 : prod[30:0];
    end
    if (ctrl.use_trq) begin
      torq_q <= prod[40:16];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      angle_from_zero   <= rel_q;
      multi_turn_angle  <= turn_accumulator;
      single_turn_angle <= turn_accumulator[28:0];
      speed             <= last_speed;
      torque            <= sat16($signed({{8{torq_q[24]}}, torq_q}));
      current           <= sat16(prod[48:16]);
      online            <= online_flag;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mfat_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_check: port-level checks for the angle tracker
// Watches the top-level ports and is attached to every instance by bind.
// ----------------------------------------------------------------------------
module mfat_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [47:0] multi_turn_angle,
  input wire logic [28:0]        single_turn_angle,
  input wire logic signed [28:0] speed
);

  // A result that has not been taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(multi_turn_angle) && $stable(speed))
    else $error("pending result changed before its transfer");

  // The single-turn angle is the accumulator taken modulo one turn.
  a_single_turn: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> single_turn_angle == multi_turn_angle[28:0])
    else $error("single-turn angle disagrees with multi-turn angle");

  // A frame occupies the sequencer: no second transfer in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a frame is in progress");

  // No result can appear within the first cycles after a frame enters an
  // otherwise empty block.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result offered too early");

endmodule

bind motor_feedback_angle_tracker mfat_check u_mfat_check (.*);
`default_nettype wire

// ----- tb/sv/motor_feedback_angle_tracker_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker_checker: shaft position predictor and checker
// Watches the register port and both channels of the angle tracker, predicts
// each reading from its own copy of the tracker state and compares it, field by
// field, with the reading that the block hands out.
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [12:0]        raw_angle,
  input  logic signed [15:0] raw_torque,
  input  logic [15:0]        frame_rate,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [12:0]        angle_from_zero,
  input  logic signed [47:0] multi_turn_angle,
  input  logic [28:0]        single_turn_angle,
  input  logic signed [28:0] speed,
  input  logic signed [15:0] torque,
  input  logic signed [15:0] current,
  input  logic               online,
  output int                 mismatches,
  output int                 outstanding,
  output int                 frames_checked
);

  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint SPD_MAX = 268435455;
  localparam longint SPD_MIN = -268435456;

  typedef struct packed {
    logic [12:0]        angle_from_zero;
    logic signed [47:0] multi_turn_angle;
    logic [28:0]        single_turn_angle;
    logic signed [28:0] speed;
    logic signed [15:0] torque;
    logic signed [15:0] current;
    logic               online;
  } shaft_reading_t;

  // Register copies
  logic [12:0] zero_count;
  logic [16:0] inv_ratio;
  logic [23:0] torque_gain;
  logic [23:0] current_gain;

  // Tracker state
  logic [12:0] last_angle;
  bit          is_online;
  longint      turn_acc;
  longint      held_speed;

  shaft_reading_t predicted_readings[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic shaft_reading_t track_frame(logic [12:0] angle,
                                                 logic signed [15:0] tcode,
                                                 logic [15:0] rate);
    shaft_reading_t r;
    longint rel;
    longint diff;
    longint inc;
    longint acc;
    longint torq;
    longint curr;
    rel = longint'(angle) - longint'(zero_count);
    if (rel < 0) rel += mfat_pkg::ENCODER_SPAN;
    // Shortest arc: exactly half a turn is taken as it stands.
    diff = longint'(angle) - longint'(last_angle);
    if (diff > mfat_pkg::HALF_SPAN) diff -= mfat_pkg::ENCODER_SPAN;
    else if (diff < -mfat_pkg::HALF_SPAN) diff += mfat_pkg::ENCODER_SPAN;
    inc = diff * longint'(inv_ratio);
    acc = turn_acc;
    // The first movement while offline syncs the accumulator to the raw angle.
    if (!is_online && last_angle != angle) begin
      is_online = 1'b1;
      inc = 0;
      acc = longint'(angle) * longint'(inv_ratio);
    end
    if (rate > 16'd1) held_speed = clip((inc * longint'(rate)) >>> 16, SPD_MIN, SPD_MAX);
    last_angle = angle;
    turn_acc = clip(acc + inc, ACC_MIN, ACC_MAX);
    torq = (longint'(tcode) * longint'(torque_gain)) >>> 16;
    curr = (torq * longint'(current_gain)) >>> 16;
    r.angle_from_zero   = rel[12:0];
    r.multi_turn_angle  = turn_acc[47:0];
    r.single_turn_angle = turn_acc[28:0];
    r.speed             = held_speed[28:0];
    r.torque            = clip(torq, -32768, 32767);
    r.current           = clip(curr, -32768, 32767);
    r.online            = is_online;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR reading %0d: %s", frames_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  initial begin
    mismatches     = 0;
    frames_checked = 0;
    outstanding    = 0;
  end

  always @(posedge clk) begin
    shaft_reading_t seen;
    shaft_reading_t want;
    if (rst) begin
      zero_count   = '0;
      inv_ratio    = 17'd65536;
      torque_gain  = 24'd65536;
      current_gain = 24'd65536;
      last_angle   = '0;
      is_online    = 1'b0;
      turn_acc     = 0;
      held_speed   = 0;
      predicted_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mfat_pkg::REG_ZERO_OFFSET:  zero_count   = cfg_data[12:0];
          mfat_pkg::REG_INV_RATIO:    inv_ratio    = cfg_data[16:0];
          mfat_pkg::REG_TORQUE_GAIN:  torque_gain  = cfg_data;
          mfat_pkg::REG_CURRENT_GAIN: current_gain = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predicted_readings.push_back(track_frame(raw_angle, raw_torque, frame_rate));
      if (out_valid && out_ready) begin
        seen = '{angle_from_zero, multi_turn_angle, single_turn_angle, speed,
                 torque, current, online};
        if (predicted_readings.size() == 0) begin
          report_mismatch("result transfer with no frame outstanding");
        end else begin
          want = predicted_readings.pop_front();
          check_field("angle_from_zero", seen.angle_from_zero, want.angle_from_zero);
          check_field("multi_turn_angle", seen.multi_turn_angle, want.multi_turn_angle);
          check_field("single_turn_angle", seen.single_turn_angle,
                      want.single_turn_angle);
          check_field("speed", seen.speed, want.speed);
          check_field("torque", seen.torque, want.torque);
          check_field("current", seen.current, want.current);
          check_field("online", seen.online, want.online);
        end
        frames_checked++;
      end
    end
    outstanding <= predicted_readings.size();
  end

endmodule

// ----- tb/sv/motor_feedback_angle_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker_tb: stimulus and verdict for the angle tracker
// Loads a series of register settings, from the extremes to random ones, and
// feeds directed and random feedback frames with random gaps and output stalls;
// the checker beside the block predicts and compares every reading.
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker_tb;

  // Far beyond the longest quiet spell of a correct run, which comes from a
  // register load and drain or from a run of random gaps.
  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = mfat_pkg::REG_ZERO_OFFSET;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [12:0]        raw_angle = '0;
  logic signed [15:0] raw_torque = '0;
  logic [15:0]        frame_rate = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [12:0]        angle_from_zero;
  logic signed [47:0] multi_turn_angle;
  logic [28:0]        single_turn_angle;
  logic signed [28:0] speed;
  logic signed [15:0] torque;
  logic signed [15:0] current;
  logic               online;

  logic        quiet = 1'b0;
  logic [12:0] shaft_angle = '0;
  int          mismatches;
  int          outstanding;
  int          frames_checked;
  int          settings_loaded = 0;

  motor_feedback_angle_tracker dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_angle        (raw_angle),
    .raw_torque       (raw_torque),
    .frame_rate       (frame_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .angle_from_zero  (angle_from_zero),
    .multi_turn_angle (multi_turn_angle),
    .single_turn_angle(single_turn_angle),
    .speed            (speed),
    .torque           (torque),
    .current          (current),
    .online           (online)
  );

  motor_feedback_angle_tracker_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_angle        (raw_angle),
    .raw_torque       (raw_torque),
    .frame_rate       (frame_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .angle_from_zero  (angle_from_zero),
    .multi_turn_angle (multi_turn_angle),
    .single_turn_angle(single_turn_angle),
    .speed            (speed),
    .torque           (torque),
    .current          (current),
    .online           (online),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .frames_checked   (frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_ready <= quiet || ($urandom_range(99) >= 7);

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("motor_feedback_angle_tracker test failed");
    $finish;
  end

  task automatic put_register(logic [1:0] idx, logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [12:0] zero, logic [16:0] ratio,
                               logic [23:0] tgain, logic [23:0] cgain);
    put_register(mfat_pkg::REG_ZERO_OFFSET, 24'(zero));
    put_register(mfat_pkg::REG_INV_RATIO, 24'(ratio));
    put_register(mfat_pkg::REG_TORQUE_GAIN, tgain);
    put_register(mfat_pkg::REG_CURRENT_GAIN, cgain);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Holds the frame until its transfer; idle cycles may come before it.
  task automatic send_frame(logic [12:0] angle, logic signed [15:0] tcode,
                            logic [15:0] rate);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_angle  <= angle;
    raw_torque <= tcode;
    frame_rate <= rate;
    shaft_angle = angle;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // Half are small steps of a turning shaft; the rest are steps around half a
  // turn, jumps anywhere and standstill.
  task automatic send_random_frames(int count);
    logic [12:0]        angle;
    logic signed [15:0] tcode;
    logic [15:0]        rate;
    int                 pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50)
        angle = shaft_angle + 13'(int'($urandom_range(600)) - 300);
      else if (pick < 65)
        angle = $urandom_range(1) ? shaft_angle + 13'($urandom_range(4098, 4094))
                                  : shaft_angle - 13'($urandom_range(4098, 4094));
      else if (pick < 85)
        angle = 13'($urandom);
      else
        angle = shaft_angle;
      case ($urandom_range(9))
        0: tcode = -16'sd32768;
        1: tcode = 16'sd32767;
        2: tcode = 16'(int'($urandom_range(2)) - 1);
        default: tcode = 16'($urandom);
      endcase
      case ($urandom_range(9))
        0: rate = 16'($urandom_range(1));
        1: rate = 16'hFFFF;
        2, 3: rate = 16'($urandom_range(1100, 900));
        default: rate = 16'($urandom);
      endcase
      send_frame(angle, tcode, rate);
    end
  endtask

  initial begin
    logic [16:0] ratio;
    logic [23:0] tgain;
    logic [23:0] cgain;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_settings(13'd5000, 17'd65536, 24'd65536, 24'd65536);
    // Standstill keeps the block offline; the first move brings it online.
    send_frame(13'd0, 16'sd0, 16'd0);
    send_frame(13'd0, 16'sd32767, 16'd1000);
    send_frame(13'd8191, -16'sd32768, 16'd65535);
    // Steps of exactly half a turn either way, then just beyond it.
    send_frame(13'd4095, 16'sd100, 16'd2);
    send_frame(13'd8191, -16'sd100, 16'd65535);
    send_frame(13'd4094, 16'sd1, 16'd1);
    send_frame(13'd0, -16'sd1, 16'd0);
    send_frame(13'd4097, 16'sd0, 16'd3);
    send_frame(13'd1, 16'sd32767, 16'd65535);
    send_frame(13'd1, -16'sd32768, 16'd100);
    send_frame(13'd2, -16'sd1, 16'd2);
    send_frame(13'd8190, 16'sd1, 16'd50000);
    // Either side of the zero offset.
    send_frame(13'd4999, 16'sd12345, 16'd1000);
    send_frame(13'd5000, -16'sd12345, 16'd1000);
    drain();

    load_settings(13'd8191, 17'h1FFFF, 24'hFFFFFF, 24'd0);
    send_random_frames(90);
    drain();
    load_settings(13'd0, 17'd0, 24'd0, 24'hFFFFFF);
    send_random_frames(90);
    drain();
    load_settings(13'd1, 17'd1, 24'd1, 24'd1);
    send_random_frames(90);
    drain();

    for (int p = 0; p < 6; p++) begin
      quiet <= (p == 2);
      case ($urandom_range(3))
        0: ratio = 17'd65536;
        1: ratio = 17'($urandom_range(65536, 1));
        2: ratio = 17'($urandom);
        default: ratio = 17'($urandom_range(8192, 1));
      endcase
      tgain = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(131072));
      cgain = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(131072));
      load_settings(13'($urandom), ratio, tgain, cgain);
      send_random_frames(145);
      drain();
    end

    $display("Summary: %0d readings checked under %0d register settings, from the offline",
             frames_checked, settings_loaded);
    $display("start through half-turn steps, held and saturated speed, torque and current.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("motor_feedback_angle_tracker test passed");
    end else begin
      $display("motor_feedback_angle_tracker test failed");
    end
    $finish;
  end

endmodule
